/* sv/u8250_pkg.sv */
// shared types, codes and lookup functions for the 8250 register model
package u8250_pkg;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_RXB   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] offset;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_drained;
  } rsp_t;

  typedef struct packed {
    mode_t      op;
    logic [2:0] offset;
    logic [7:0] data;
  } cmd_t;

  localparam logic [2:0] OFF_DATA = 3'd0;
  localparam logic [2:0] OFF_IER  = 3'd1;
  localparam logic [2:0] OFF_IIR  = 3'd2;
  localparam logic [2:0] OFF_LCR  = 3'd3;
  localparam logic [2:0] OFF_MCR  = 3'd4;
  localparam logic [2:0] OFF_LSR  = 3'd5;
  localparam logic [2:0] OFF_MSR  = 3'd6;

  localparam logic [2:0] CAUSE_RDA  = 3'd0;
  localparam logic [2:0] CAUSE_THRE = 3'd1;
  localparam logic [2:0] CAUSE_RLS  = 3'd2;
  localparam logic [2:0] CAUSE_MSR  = 3'd3;
  localparam logic [2:0] CAUSE_NONE = 3'd4;

  localparam logic [3:0] IIR_HIGH = 4'hc;

  function automatic logic [2:0] cause_rank(input logic [1:0] c);
    case (c)
      2'd0: cause_rank = 3'd2;
      2'd1: cause_rank = 3'd4;
      2'd2: cause_rank = 3'd1;
      default: cause_rank = 3'd5;
    endcase
  endfunction

  function automatic logic [1:0] iir_code(input logic [1:0] c);
    case (c)
      2'd0: iir_code = 2'd2;
      2'd1: iir_code = 2'd1;
      2'd2: iir_code = 2'd3;
      default: iir_code = 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] trig_level(input logic [1:0] sel);
    case (sel)
      2'd0: trig_level = 8'd1;
      2'd1: trig_level = 8'd4;
      2'd2: trig_level = 8'd8;
      default: trig_level = 8'd14;
    endcase
  endfunction

  function automatic logic [7:0] ident_byte(input logic [2:0] pend);
    if (pend == CAUSE_NONE) ident_byte = {IIR_HIGH, 4'h1};
    else ident_byte = {IIR_HIGH, 1'b0, iir_code(pend[1:0]), 1'b0};
  endfunction

  function automatic logic [2:0] raise_cause(input logic [2:0] pend, input logic [3:0] ier,
                                             input logic [2:0] c);
    raise_cause = pend;
    if (!(pend != CAUSE_NONE && cause_rank(c[1:0]) > cause_rank(pend[1:0]))) begin
      if (ier[c[1:0]]) raise_cause = c;
    end
  endfunction

  function automatic logic [2:0] drop_cause(input logic [2:0] pend, input logic [2:0] c);
    drop_cause = (pend == c) ? CAUSE_NONE : pend;
  endfunction

endpackage

/* sv/u8250_queue.sv */
// two-entry queue used between stages
module u8250_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  logic [W-1:0] slot [2];
  logic wp, rp;
  logic [1:0] count;
  logic do_push, do_pop;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slot[rp];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) slot[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

/* sv/u8250_front.sv */
// front end: takes request transfers, decodes them and queues commands
module u8250_front import u8250_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t req,
  output logic full,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_pop
);
  cmd_t dec;
  logic [$bits(cmd_t)-1:0] q_out;
  logic q_empty;

  always_comb begin
    dec.offset = req.offset;
    dec.data = req.data;
    case (req.mode)
      MODE_READ:  dec.op = MODE_READ;
      MODE_WRITE: dec.op = MODE_WRITE;
      MODE_TICK:  dec.op = MODE_TICK;
      default:    dec.op = MODE_RXB;
    endcase
    // offset only matters for bus accesses
    if (req.mode == MODE_TICK || req.mode == MODE_RXB) dec.offset = 3'd0;
    if (req.mode == MODE_READ || req.mode == MODE_TICK) dec.data = 8'd0;
  end

  u8250_queue #(.W($bits(cmd_t))) cmd_q (
    .clk(clk), .rst(rst), .push(push), .wdata(dec), .full(full),
    .pop(cmd_pop), .rdata(q_out), .empty(q_empty)
  );

  assign cmd_valid = !q_empty;
  assign cmd = cmd_t'(q_out);
endmodule

/* sv/u8250_core.sv */
// back end: register file, fifos and interrupt logic, one command per cycle while the response queue has room
module u8250_core import u8250_pkg::*; #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output rsp_t res
);
  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [CW:0] DEPTH_C = (CW+1)'(FIFO_DEPTH);
  localparam logic [AW-1:0] LAST_C = AW'(FIFO_DEPTH - 1);

  logic [7:0] tx_mem [FIFO_DEPTH];
  logic [7:0] rx_mem [FIFO_DEPTH];
  logic [7:0] tx_front, rx_front;

  logic [3:0] ier, ier_next;
  logic [7:0] fcr, fcr_next, lcr, lcr_next, mcr, mcr_next;
  logic [7:0] lsr, lsr_next, msr, msr_next;
  logic [15:0] div, div_next, cnt, cnt_next;
  logic [2:0] pend, pend_next;
  logic [AW-1:0] tx_head, tx_head_next, rx_head, rx_head_next;
  logic [CW-1:0] tx_count, tx_count_next, rx_count, rx_count_next;

  logic tx_we, rx_we;
  logic [AW-1:0] tx_waddr, rx_waddr;
  logic [7:0] tx_wdata, rx_wdata;
  logic [CW:0] tx_sum, rx_sum;
  logic [AW-1:0] tx_tail, rx_tail;
  logic go;

  assign go = cmd_valid && !res_full;
  assign cmd_pop = go;
  assign res_push = go;

  always_comb begin
    tx_sum = (CW+1)'(tx_head) + (CW+1)'(tx_count);
    if (tx_sum >= DEPTH_C) tx_sum = tx_sum - DEPTH_C;
    tx_tail = tx_sum[AW-1:0];
    rx_sum = (CW+1)'(rx_head) + (CW+1)'(rx_count);
    if (rx_sum >= DEPTH_C) rx_sum = rx_sum - DEPTH_C;
    rx_tail = rx_sum[AW-1:0];
  end

  always_comb begin
    ier_next = ier; fcr_next = fcr; lcr_next = lcr; mcr_next = mcr;
    lsr_next = lsr; msr_next = msr; div_next = div; cnt_next = cnt;
    pend_next = pend;
    tx_head_next = tx_head; tx_count_next = tx_count;
    rx_head_next = rx_head; rx_count_next = rx_count;
    tx_we = 1'b0; tx_waddr = tx_tail; tx_wdata = cmd.data;
    rx_we = 1'b0; rx_waddr = rx_tail; rx_wdata = cmd.data;
    res = '0;
    if (go) begin
      case (cmd.op)
        MODE_READ: begin
          case (cmd.offset)
            OFF_DATA: begin
              if (lcr[7]) begin
                res.read_data = div[7:0];
              end else begin
                if (rx_count != '0) begin
                  res.read_data = rx_front;
                  rx_head_next = (rx_head == LAST_C) ? '0 : rx_head + 1'b1;
                  rx_count_next = rx_count - 1'b1;
                end
                lsr_next[0] = (rx_count_next != '0);
                if (16'(rx_count_next) < 16'(trig_level(fcr[7:6])))
                  pend_next = drop_cause(pend_next, CAUSE_RDA);
              end
            end
            OFF_IER: res.read_data = lcr[7] ? div[15:8] : {4'd0, ier};
            OFF_IIR: begin
              res.read_data = ident_byte(pend);
              pend_next = drop_cause(pend, CAUSE_THRE);
            end
            OFF_LCR: res.read_data = lcr;
            OFF_MCR: res.read_data = mcr;
            OFF_LSR: begin
              res.read_data = lsr;
              lsr_next[1] = 1'b0;
              pend_next = drop_cause(pend, CAUSE_RLS);
            end
            OFF_MSR: res.read_data = msr;
            default: res.read_data = 8'd0;
          endcase
        end
        MODE_WRITE: begin
          case (cmd.offset)
            OFF_DATA: begin
              if (lcr[7]) begin
                div_next[7:0] = cmd.data;
              end else if ((CW+1)'(tx_count) < DEPTH_C) begin
                tx_we = 1'b1;
                tx_count_next = tx_count + 1'b1;
                lsr_next[6:5] = 2'b00;
                pend_next = drop_cause(pend, CAUSE_THRE);
              end
            end
            OFF_IER: begin
              if (lcr[7]) div_next[15:8] = cmd.data;
              else ier_next = cmd.data[3:0];
            end
            OFF_IIR: begin
              fcr_next = cmd.data;
              if (cmd.data[1]) begin
                rx_count_next = '0;
                rx_head_next = '0;
              end
              if (cmd.data[2]) begin
                tx_count_next = '0;
                tx_head_next = '0;
              end
            end
            OFF_LCR: lcr_next = cmd.data;
            OFF_MCR: begin
              mcr_next = cmd.data;
              if (cmd.data[4]) begin
                msr_next = {cmd.data[3], cmd.data[2], cmd.data[0], cmd.data[1], msr[3:0]};
              end else begin
                msr_next[7:6] = 2'b00;
              end
            end
            default: ;
          endcase
        end
        MODE_TICK: begin
          if (cnt >= div) begin
            cnt_next = 16'd0;
            if (tx_count != '0) begin
              tx_head_next = (tx_head == LAST_C) ? '0 : tx_head + 1'b1;
              tx_count_next = tx_count - 1'b1;
              if (mcr[4]) begin
                if ((CW+1)'(rx_count) < DEPTH_C) begin
                  rx_we = 1'b1;
                  rx_wdata = tx_front;
                  rx_count_next = rx_count + 1'b1;
                end
              end else begin
                res.tx_valid = 1'b1;
                res.tx_byte = tx_front;
              end
              if (tx_count_next == '0) begin
                lsr_next[6] = 1'b1;
                res.tx_drained = 1'b1;
              end
            end
            if (tx_count_next == '0) begin
              lsr_next[5] = 1'b1;
              pend_next = raise_cause(pend_next, ier, CAUSE_THRE);
            end
          end else begin
            cnt_next = cnt + 16'd1;
          end
        end
        default: begin
          if ((CW+1)'(rx_count) + 1'b1 >= DEPTH_C) begin
            lsr_next[1] = 1'b1;
            pend_next = raise_cause(pend_next, ier, CAUSE_RLS);
          end else begin
            rx_we = 1'b1;
            rx_count_next = rx_count + 1'b1;
          end
          lsr_next[0] = (rx_count_next != '0);
          pend_next = raise_cause(pend_next, ier, CAUSE_RDA);
        end
      endcase
      res.irq = (pend_next != CAUSE_NONE);
    end
  end

  // ring storage with the head entry read ahead
  always_ff @(posedge clk) begin
    if (tx_we) tx_mem[tx_waddr] <= tx_wdata;
    if (tx_we && tx_waddr == tx_head_next) tx_front <= tx_wdata;
    else tx_front <= tx_mem[tx_head_next];
  end

  always_ff @(posedge clk) begin
    if (rx_we) rx_mem[rx_waddr] <= rx_wdata;
    if (rx_we && rx_waddr == rx_head_next) rx_front <= rx_wdata;
    else rx_front <= rx_mem[rx_head_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ier <= 4'd0; fcr <= 8'hc0; lcr <= 8'h03; mcr <= 8'd0;
      lsr <= 8'd0; msr <= 8'd0; div <= 16'd0; cnt <= 16'd0;
      pend <= CAUSE_NONE;
      tx_head <= '0; tx_count <= '0; rx_head <= '0; rx_count <= '0;
    end else begin
      ier <= ier_next; fcr <= fcr_next; lcr <= lcr_next; mcr <= mcr_next;
      lsr <= lsr_next; msr <= msr_next; div <= div_next; cnt <= cnt_next;
      pend <= pend_next;
      tx_head <= tx_head_next; tx_count <= tx_count_next;
      rx_head <= rx_head_next; rx_count <= rx_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_tx_bound: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(tx_count) <= DEPTH_C) else $error("tx count overflow");
  a_rx_bound: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(rx_count) <= DEPTH_C) else $error("rx count overflow");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (go && res.tx_drained) |=> (tx_count == '0)) else $error("drain with bytes left");
  a_loop: assert property (@(posedge clk) disable iff (rst)
    (go && res.tx_valid) |-> !mcr[4]) else $error("line output in loopback");
`endif
endmodule

/* sv/uart_8250_register_model_top.sv */
// top level of the 8250 uart register model
//
// request channel: push/full with req (mode, offset, data); a transfer
// happens on a clock edge with push high and full low
// response channel: empty/pop with rsp; rsp holds the oldest response while
// empty is low, a transfer happens on an edge with pop high and empty low
// every request gives exactly one response, in order
// path: a request transfer is registered in the command queue, the back end
// forms its response combinationally and the response queue registers it
// before it shows on rsp; the back end holds while the response queue is full
// throughput: one request per cycle unless the response queue is full, set by
// the register and fifo update in the back end; ring heads are read ahead from
// the byte stores; if pop stays low the response queue fills, the back end holds,
// and then the command queue fills and full rises
// reset (rst, synchronous) empties both queues and puts registers to their
// power-on values: ier 0, iir 0xc1, fcr 0xc0, lcr 0x03, fifos empty
module uart_8250_register_model_top import u8250_pkg::*; #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t req,
  output logic full,
  output logic empty,
  input  logic pop,
  output rsp_t rsp
);
  logic cmd_valid, cmd_pop, res_full, res_push;
  cmd_t cmd;
  rsp_t res;
  logic [$bits(rsp_t)-1:0] q_out;

  u8250_front front (
    .clk(clk), .rst(rst), .push(push), .req(req), .full(full),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  u8250_core #(.FIFO_DEPTH(FIFO_DEPTH)) core (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .res_full(res_full), .res_push(res_push), .res(res)
  );

  u8250_queue #(.W($bits(rsp_t))) rsp_q (
    .clk(clk), .rst(rst), .push(res_push), .wdata(res), .full(res_full),
    .pop(pop), .rdata(q_out), .empty(empty)
  );

  assign rsp = rsp_t'(q_out);
endmodule

/* tb/tb.sv */
// testbench for the 8250 uart register model: predicts each response and checks it in order
module tb;
  import u8250_pkg::*;

  localparam int DEPTH = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  req_t req = '0;
  logic full;
  logic empty;
  logic pop = 1'b0;
  rsp_t rsp;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  rsp_t expected_q[$];

  logic [3:0] m_ier;
  logic [7:0] m_iir, m_fcr, m_lcr, m_mcr, m_lsr, m_msr;
  logic [15:0] m_div, m_cnt;
  logic [2:0] m_pend;
  logic [7:0] m_tx[DEPTH];
  logic [7:0] m_rx[DEPTH];
  int m_txn, m_txh, m_rxn, m_rxh;

  uart_8250_register_model_top #(.FIFO_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst), .push(push), .req(req), .full(full),
    .empty(empty), .pop(pop), .rsp(rsp)
  );

  always #5 clk = ~clk;

  function automatic int rank_of(input logic [1:0] c);
    case (c)
      2'd0: return 2;
      2'd1: return 4;
      2'd2: return 1;
      default: return 5;
    endcase
  endfunction

  function automatic logic [1:0] code_of(input logic [1:0] c);
    case (c)
      2'd0: return 2'd2;
      2'd1: return 2'd1;
      2'd2: return 2'd3;
      default: return 2'd0;
    endcase
  endfunction

  function automatic int trigger_of(input logic [1:0] s);
    case (s)
      2'd0: return 1;
      2'd1: return 4;
      2'd2: return 8;
      default: return 14;
    endcase
  endfunction

  task automatic uart_reset_state();
    m_ier = '0; m_iir = 8'hc1; m_fcr = 8'hc0; m_lcr = 8'h03; m_mcr = '0;
    m_lsr = '0; m_msr = '0; m_div = '0; m_cnt = '0; m_pend = CAUSE_NONE;
    m_txn = 0; m_txh = 0; m_rxn = 0; m_rxh = 0;
    foreach (m_rx[i]) m_rx[i] = '0;
  endtask

  task automatic raise(input logic [2:0] c);
    if (!m_iir[0] && m_pend != CAUSE_NONE && rank_of(c[1:0]) > rank_of(m_pend[1:0])) return;
    if (!m_ier[c[1:0]]) return;
    m_iir = {m_iir[7:4], 1'b0, code_of(c[1:0]), 1'b0};
    m_pend = c;
  endtask

  task automatic lower(input logic [2:0] c);
    if (m_pend == c) begin
      m_iir = {m_iir[7:4], 4'h1};
      m_pend = CAUSE_NONE;
    end
  endtask

  task automatic rx_take(output logic [7:0] b);
    b = '0;
    if (m_rxn != 0) begin
      b = m_rx[m_rxh];
      m_rxh = (m_rxh + 1) % DEPTH;
      m_rxn--;
    end
    m_lsr[0] = (m_rxn != 0);
    if (m_rxn < trigger_of(m_fcr[7:6])) lower(CAUSE_RDA);
  endtask

  task automatic uart_predict(input req_t r, output rsp_t o);
    logic [7:0] b;
    o = '0;
    case (mode_t'(r.mode))
      MODE_READ: begin
        case (r.offset)
          OFF_DATA: if (m_lcr[7]) o.read_data = m_div[7:0];
                    else begin rx_take(b); o.read_data = b; end
          OFF_IER: o.read_data = m_lcr[7] ? m_div[15:8] : {4'h0, m_ier};
          OFF_IIR: begin o.read_data = m_iir; lower(CAUSE_THRE); end
          OFF_LCR: o.read_data = m_lcr;
          OFF_MCR: o.read_data = m_mcr;
          OFF_LSR: begin o.read_data = m_lsr; m_lsr[1] = 1'b0; lower(CAUSE_RLS); end
          OFF_MSR: o.read_data = m_msr;
          default: o.read_data = '0;
        endcase
      end
      MODE_WRITE: begin
        case (r.offset)
          OFF_DATA: if (m_lcr[7]) m_div[7:0] = r.data;
                    else if (m_txn < DEPTH) begin
                      m_tx[(m_txh + m_txn) % DEPTH] = r.data;
                      m_txn++;
                      m_lsr[6:5] = 2'b00;
                      lower(CAUSE_THRE);
                    end
          OFF_IER: if (m_lcr[7]) m_div[15:8] = r.data; else m_ier = r.data[3:0];
          OFF_IIR: begin
            m_fcr = r.data;
            if (r.data[1]) begin m_rxn = 0; m_rxh = 0; end
            if (r.data[2]) begin m_txn = 0; m_txh = 0; end
          end
          OFF_LCR: m_lcr = r.data;
          OFF_MCR: begin
            m_mcr = r.data;
            if (r.data[4]) m_msr = {r.data[3], r.data[2], r.data[0], r.data[1], m_msr[3:0]};
            else m_msr[7:6] = 2'b00;
          end
          default: ;
        endcase
      end
      MODE_TICK: begin
        if (m_cnt >= m_div) begin
          m_cnt = '0;
          if (m_txn != 0) begin
            b = m_tx[m_txh];
            m_txh = (m_txh + 1) % DEPTH;
            m_txn--;
            if (m_mcr[4]) begin
              if (m_rxn < DEPTH) begin
                m_rx[(m_rxh + m_rxn) % DEPTH] = b;
                m_rxn++;
              end
            end else begin
              o.tx_valid = 1'b1;
              o.tx_byte = b;
            end
            if (m_txn == 0) begin m_lsr[6] = 1'b1; o.tx_drained = 1'b1; end
          end
          if (m_txn == 0) begin m_lsr[5] = 1'b1; raise(CAUSE_THRE); end
        end else m_cnt = m_cnt + 16'd1;
      end
      default: begin
        if (m_rxn + 1 >= DEPTH) begin
          m_lsr[1] = 1'b1;
          raise(CAUSE_RLS);
        end else begin
          m_rx[(m_rxh + m_rxn) % DEPTH] = r.data;
          m_rxn++;
        end
        m_lsr[0] = (m_rxn != 0);
        raise(CAUSE_RDA);
      end
    endcase
    o.irq = (m_pend != CAUSE_NONE);
  endtask

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] exp);
    errors++;
    if (errors <= 40) $display("mismatch %s: got %02h expected %02h", what, got, exp);
  endtask

  task automatic send(input logic [1:0] mode, input logic [2:0] offset, input logic [7:0] data);
    req_t r;
    rsp_t o;
    r.mode = mode; r.offset = offset; r.data = data;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    req <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    uart_predict(r, o);
    expected_q.push_back(o);
    @(negedge clk);
  endtask

  // receiver side, one decision per cycle
  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else if (hold_cycles > 0) begin
      pop <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else pop <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) report("unexpected transfer", rsp.read_data, 8'h00);
      else begin
        e = expected_q.pop_front();
        if (rsp.read_data !== e.read_data) report("read_data", rsp.read_data, e.read_data);
        if (rsp.irq !== e.irq) report("irq", {7'h0, rsp.irq}, {7'h0, e.irq});
        if (rsp.tx_valid !== e.tx_valid) report("tx_valid", {7'h0, rsp.tx_valid}, {7'h0, e.tx_valid});
        if (rsp.tx_byte !== e.tx_byte) report("tx_byte", rsp.tx_byte, e.tx_byte);
        if (rsp.tx_drained !== e.tx_drained)
          report("tx_drained", {7'h0, rsp.tx_drained}, {7'h0, e.tx_drained});
      end
    end
  end

  task automatic drain();
    push <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send(MODE_READ, OFF_IIR, 8'h00);
    send(MODE_READ, OFF_LCR, 8'h00);
    send(MODE_READ, OFF_DATA, 8'h00);
    send(MODE_WRITE, OFF_IER, 8'hff);
    send(MODE_TICK, 3'd0, 8'h00);
    send(MODE_READ, OFF_IIR, 8'h00);
    send(MODE_WRITE, OFF_DATA, 8'ha5);
    send(MODE_WRITE, OFF_DATA, 8'h5a);
    send(MODE_TICK, 3'd7, 8'hff);
    send(MODE_TICK, 3'd0, 8'h00);
    send(MODE_RXB, 3'd0, 8'hff);
    send(MODE_READ, OFF_DATA, 8'h00);
    send(MODE_WRITE, 3'd7, 8'hff);
    send(MODE_READ, 3'd7, 8'h00);
    send(MODE_WRITE, OFF_LSR, 8'hff);
    send(MODE_WRITE, OFF_MSR, 8'hff);
    send(MODE_WRITE, OFF_MCR, 8'h1f);
    send(MODE_READ, OFF_MSR, 8'h00);
    send(MODE_WRITE, OFF_MCR, 8'h00);
    send(MODE_WRITE, OFF_LCR, 8'h80);
    send(MODE_WRITE, OFF_DATA, 8'hff);
    send(MODE_WRITE, OFF_IER, 8'hff);
    send(MODE_READ, OFF_IER, 8'h00);
    send(MODE_WRITE, OFF_LCR, 8'h03);
    send(MODE_READ, OFF_LSR, 8'h00);
  endtask

  task automatic test_overrun_and_full();
    for (int i = 0; i < 18; i++) send(MODE_RXB, 3'($urandom), 8'($urandom));
    send(MODE_READ, OFF_LSR, 8'h00);
    for (int i = 0; i < 18; i++) send(MODE_WRITE, OFF_DATA, 8'($urandom));
    send(MODE_WRITE, OFF_MCR, 8'h10);
    for (int i = 0; i < 18; i++) send(MODE_TICK, 3'd0, 8'h00);
    for (int i = 0; i < 17; i++) send(MODE_READ, OFF_DATA, 8'h00);
    send(MODE_WRITE, OFF_IIR, 8'h06);
    send(MODE_WRITE, OFF_MCR, 8'h00);
  endtask

  task automatic random_item();
    int k;
    k = $urandom_range(99);
    if (k < 22) send(MODE_WRITE, OFF_DATA, 8'($urandom));
    else if (k < 42) send(MODE_TICK, 3'($urandom), 8'($urandom));
    else if (k < 60) send(MODE_RXB, 3'($urandom), 8'($urandom));
    else if (k < 84) send(MODE_READ, 3'($urandom), 8'($urandom));
    else if (k < 88) send(MODE_WRITE, OFF_IER, 8'($urandom));
    else if (k < 91) send(MODE_WRITE, OFF_IIR, 8'($urandom) & 8'hc1 |
                          ($urandom_range(9) == 0 ? 8'($urandom) & 8'h06 : 8'h00) |
                          8'($urandom) & 8'h38);
    else if (k < 94) send(MODE_WRITE, OFF_MCR, 8'($urandom));
    else if (k < 96) send(MODE_WRITE, OFF_LCR, 8'($urandom) & 8'h7f);
    else if (k < 98) begin
      send(MODE_WRITE, OFF_LCR, 8'h80 | 8'($urandom));
      send(MODE_WRITE, OFF_DATA, 8'($urandom_range(3)));
      send(MODE_WRITE, OFF_IER, $urandom_range(19) == 0 ? 8'($urandom) : 8'h00);
      send(MODE_READ, 3'($urandom_range(1)), 8'h00);
      send(MODE_WRITE, OFF_LCR, 8'h03);
    end else send(MODE_WRITE, 3'($urandom_range(5, 7)), 8'($urandom));
  endtask

  task automatic test_random(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (int i = 0; i < n; i++) random_item();
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_cycles = 200;
    for (int i = 0; i < 60; i++) random_item();
    drain();
  endtask

  initial begin
    uart_reset_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_overrun_and_full();
    drain();
    test_random(300, 0, 0);
    test_random(250, 55, 0);
    test_random(250, 0, 55);
    test_random(250, 13, 13);
    test_backpressure();
    drain();
    repeat (10) @(negedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* uart_8250_register_model_top.f */
sv/u8250_pkg.sv
sv/u8250_queue.sv
sv/u8250_front.sv
sv/u8250_core.sv
sv/uart_8250_register_model_top.sv
tb/tb.sv
